// ===== src/slcp_pkg.sv =====
// Shared types and constants for the serial lamp command parser.
// Beat payload structs, character codes, reply codes and the frame check result.
// No dependencies.
package slcp_pkg;

  // Fixed field widths
  localparam int LAMP_W   = 8;
  localparam int LAMP_IW  = 3;
  localparam int CHAR_W   = 8;
  localparam int REPLY_W  = 2;

  // Only the first seven frame positions are ever examined by the check
  localparam int BUF_DEPTH = 7;
  localparam int BUF_AW    = 3;

  // Frame lengths, counting the closing '<'
  localparam int LEN_ON  = 7;
  localparam int LEN_OFF = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_END   = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_START = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_F     = 8'h46;

  // Reply codes
  localparam logic [REPLY_W-1:0] REPLY_NONE = 2'd0;
  localparam logic [REPLY_W-1:0] REPLY_OK   = 2'd1;
  localparam logic [REPLY_W-1:0] REPLY_ERR  = 2'd2;

  // Action codes
  localparam logic ACT_BYTE   = 1'b0;
  localparam logic ACT_BUTTON = 1'b1;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t [BUF_DEPTH-1:0] frame_buf_t;

  // Command beat
  typedef struct packed {
    logic               action;
    logic [CHAR_W-1:0]  rx_byte;
    logic [LAMP_IW-1:0] button_index;
  } cmd_t;

  // Response beat
  typedef struct packed {
    logic [LAMP_W-1:0]  lamps;
    logic [REPLY_W-1:0] reply;
    logic               changed;
    logic [LAMP_IW-1:0] change_lamp;
    logic               change_on;
  } rsp_t;

  // Outcome of checking a closed frame
  typedef struct packed {
    logic               ok;
    logic [LAMP_IW-1:0] lamp;
    logic               turn_on;
  } frame_check_t;

endpackage

// ===== src/slcp_frame_check.sv =====
// Combinational check of a closed frame against ">Md;ON<" and ">Md;OFF<".
// Depends on slcp_pkg.
module slcp_frame_check #(
  parameter int NUM_LAMPS = 8,
  parameter int CNT_W     = 4
) (
  input  slcp_pkg::frame_buf_t   frame,
  input  logic [CNT_W-1:0]       len,
  output slcp_pkg::frame_check_t check
);

  logic               len_on;
  logic               len_off;
  logic               digit_ok;
  logic               head_ok;
  logic               tail_ok;
  logic [slcp_pkg::CHAR_W-1:0] d;

  assign d = frame[2];

  // Length must be exactly that of the ON or the OFF form
  assign len_on  = (len == CNT_W'(slcp_pkg::LEN_ON));
  assign len_off = (len == CNT_W'(slcp_pkg::LEN_OFF));

  // Digit names a lamp that exists
  assign digit_ok = (d >= slcp_pkg::CH_ZERO) && (d <= slcp_pkg::CH_SEVEN) &&
                    (32'(d[slcp_pkg::LAMP_IW-1:0]) < NUM_LAMPS);

  assign head_ok = (frame[0] == slcp_pkg::CH_START) && (frame[1] == slcp_pkg::CH_M) &&
                   (frame[3] == slcp_pkg::CH_SEMI) && (frame[4] == slcp_pkg::CH_O);

  assign tail_ok = (len_on && frame[5] == slcp_pkg::CH_N) ||
                   (len_off && frame[5] == slcp_pkg::CH_F && frame[6] == slcp_pkg::CH_F);

  always_comb begin
    check.ok      = digit_ok && head_ok && tail_ok;
    check.lamp    = d[slcp_pkg::LAMP_IW-1:0];
    check.turn_on = len_on;
  end

endmodule

// ===== src/slcp_exec.sv =====
// Parser state (frame buffer, byte count, lamp levels) and the response register.
// Depends on slcp_pkg and slcp_frame_check.
module slcp_exec #(
  parameter int NUM_LAMPS   = 8,
  parameter int FRAME_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  slcp_pkg::cmd_t item,
  output slcp_pkg::rsp_t res
);

  localparam int CNT_W = $clog2(FRAME_DEPTH + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_DEPTH + 1);

  slcp_pkg::frame_buf_t         frame_bytes;
  logic [CNT_W-1:0]             byte_count;
  logic [CNT_W-1:0]             byte_count_next;
  logic [CNT_W-1:0]             count_inc;
  logic [slcp_pkg::LAMP_W-1:0]  lamp_levels;
  logic [slcp_pkg::LAMP_W-1:0]  lamp_levels_next;
  slcp_pkg::rsp_t               res_next;
  slcp_pkg::frame_check_t       check;
  logic                         is_on;

  // Count including this byte, saturating
  assign count_inc = (byte_count < CNT_MAX) ? byte_count + CNT_W'(1) : byte_count;

  slcp_frame_check #(
    .NUM_LAMPS (NUM_LAMPS),
    .CNT_W     (CNT_W)
  ) u_check (
    .frame (frame_bytes),
    .len   (count_inc),
    .check (check)
  );

  assign is_on = lamp_levels[check.lamp];

  // Next state and response for one beat
  always_comb begin
    lamp_levels_next     = lamp_levels;
    byte_count_next      = byte_count;
    res_next.reply       = slcp_pkg::REPLY_NONE;
    res_next.changed     = 1'b0;
    res_next.change_lamp = '0;
    res_next.change_on   = 1'b0;
    if (item.action == slcp_pkg::ACT_BUTTON) begin
      if (32'(item.button_index) < NUM_LAMPS) begin
        lamp_levels_next[item.button_index] = ~lamp_levels[item.button_index];
        res_next.changed     = 1'b1;
        res_next.change_lamp = item.button_index;
        res_next.change_on   = ~lamp_levels[item.button_index];
      end
    end else begin
      byte_count_next = count_inc;
      if (item.rx_byte == slcp_pkg::CH_END) begin
        byte_count_next = '0;
        if (check.ok) begin
          res_next.reply = slcp_pkg::REPLY_OK;
          if (check.turn_on != is_on) begin
            lamp_levels_next[check.lamp] = check.turn_on;
            res_next.changed     = 1'b1;
            res_next.change_lamp = check.lamp;
            res_next.change_on   = check.turn_on;
          end
        end else begin
          res_next.reply = slcp_pkg::REPLY_ERR;
        end
      end
    end
    res_next.lamps = lamp_levels_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      lamp_levels <= '0;
    end else if (step) begin
      byte_count  <= byte_count_next;
      lamp_levels <= lamp_levels_next;
    end
  end

  // Frame buffer and response payload
  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
      if (item.action == slcp_pkg::ACT_BYTE &&
          byte_count < CNT_W'(slcp_pkg::BUF_DEPTH)) begin
        frame_bytes[byte_count[slcp_pkg::BUF_AW-1:0]] <= item.rx_byte;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_MAX)
    else $error("byte count beyond saturation");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.action == slcp_pkg::ACT_BYTE && item.rx_byte == slcp_pkg::CH_END
    |=> byte_count == '0)
    else $error("frame end did not empty buffer");

  a_button_no_reply: assert property (@(posedge clk) disable iff (rst)
    step && item.action == slcp_pkg::ACT_BUTTON |=> res.reply == slcp_pkg::REPLY_NONE)
    else $error("reply on button beat");

  a_change_matches: assert property (@(posedge clk) disable iff (rst)
    step |=> (!res.changed || res.lamps[res.change_lamp] == res.change_on))
    else $error("reported change disagrees with lamp levels");

  a_lamps_track: assert property (@(posedge clk) disable iff (rst)
    step |=> res.lamps == lamp_levels)
    else $error("response lamps differ from state");
`endif

endmodule

// ===== src/serial_lamp_command_parser.sv =====
// Top level of the serial lamp command parser: command input register and response
// handshake around the parser state. Depends on slcp_pkg and slcp_exec.
//
// One command beat (a received byte or a button press) is accepted every clock cycle while
// the response side does not stall, and gives exactly one response beat. The beat sits
// in an input register, passes the frame compare and lamp update logic combinationally
// and lands in the response register, which also commits the byte count, frame buffer
// and lamp levels. A held response stalls the input register, so cmd_ready stays high
// while the input register is empty or moves on in the same cycle. No clearing pass
// after reset is needed.
module serial_lamp_command_parser #(
  parameter int NUM_LAMPS   = 8,
  parameter int FRAME_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  slcp_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output slcp_pkg::rsp_t rsp
);

  logic           in_full;
  slcp_pkg::cmd_t cmd_q;
  logic           advance;

  // Input register moves on when the response register is free or drains
  assign advance   = in_full && (!rsp_valid || rsp_ready);
  assign cmd_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd_ready) begin
        in_full <= cmd_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
    end
  end

  slcp_exec #(
    .NUM_LAMPS   (NUM_LAMPS),
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_exec (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (cmd_q),
    .res  (rsp)
  );

endmodule

// ===== sim/slcp_checker.sv =====
// Checker for the serial lamp command parser: watches both channels, predicts each response
// beat from its command beat and compares them field by field.
// Depends on slcp_pkg.
module slcp_checker #(
  parameter int NUM_LAMPS   = 8,
  parameter int FRAME_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_ready,
  input  slcp_pkg::cmd_t cmd,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  slcp_pkg::rsp_t rsp,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the parser state
  slcp_pkg::char_t             frame_mem [FRAME_DEPTH];
  int                          frame_len;
  logic [slcp_pkg::LAMP_W-1:0] lamp_state;

  // Responses still owed by the block, oldest first
  slcp_pkg::rsp_t response_q [$];
  int             err_count = 0;
  int             owed      = 0;

  assign errors  = err_count;
  assign pending = owed;

  task automatic report(input string msg);
    $display("ERROR %0t ns: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Decode the closed frame; only positions written by this frame are read
  function automatic logic frame_is_command(output logic [slcp_pkg::LAMP_IW-1:0] idx,
                                            output logic on);
    slcp_pkg::char_t digit;
    idx = '0;
    on  = 1'b0;
    digit = frame_mem[2];
    if (frame_len != slcp_pkg::LEN_ON && frame_len != slcp_pkg::LEN_OFF) return 1'b0;
    if (frame_mem[0] != slcp_pkg::CH_START || frame_mem[1] != slcp_pkg::CH_M) return 1'b0;
    if (digit < slcp_pkg::CH_ZERO || digit > slcp_pkg::CH_SEVEN) return 1'b0;
    if (int'(digit - slcp_pkg::CH_ZERO) >= NUM_LAMPS) return 1'b0;
    if (frame_mem[3] != slcp_pkg::CH_SEMI || frame_mem[4] != slcp_pkg::CH_O) return 1'b0;
    if (frame_len == slcp_pkg::LEN_ON && frame_mem[5] != slcp_pkg::CH_N) return 1'b0;
    if (frame_len == slcp_pkg::LEN_OFF &&
        (frame_mem[5] != slcp_pkg::CH_F || frame_mem[6] != slcp_pkg::CH_F)) return 1'b0;
    idx = slcp_pkg::LAMP_IW'(digit - slcp_pkg::CH_ZERO);
    on  = (frame_len == slcp_pkg::LEN_ON);
    return 1'b1;
  endfunction

  // Advance the shadow state by one command beat and return the response it causes
  function automatic slcp_pkg::rsp_t apply_cmd(input slcp_pkg::cmd_t c);
    slcp_pkg::rsp_t               r;
    logic [slcp_pkg::LAMP_IW-1:0] idx;
    logic                         on;
    r = '0;
    if (c.action == slcp_pkg::ACT_BUTTON) begin
      if (int'(c.button_index) < NUM_LAMPS) begin
        lamp_state[c.button_index] = ~lamp_state[c.button_index];
        r.changed     = 1'b1;
        r.change_lamp = c.button_index;
        r.change_on   = lamp_state[c.button_index];
      end
    end else begin
      if (frame_len < FRAME_DEPTH) frame_mem[frame_len] = c.rx_byte;
      if (frame_len < FRAME_DEPTH + 1) frame_len++;
      if (c.rx_byte == slcp_pkg::CH_END) begin
        if (frame_is_command(idx, on)) begin
          r.reply = slcp_pkg::REPLY_OK;
          // a command that asks for the current level changes nothing
          if (lamp_state[idx] != on) begin
            lamp_state[idx] = on;
            r.changed       = 1'b1;
            r.change_lamp   = idx;
            r.change_on     = on;
          end
        end else begin
          r.reply = slcp_pkg::REPLY_ERR;
        end
        frame_len = 0;
      end
    end
    r.lamps = lamp_state;
    return r;
  endfunction

  // Predict on each command beat, compare on each response beat
  always @(posedge clk) begin
    slcp_pkg::rsp_t want;
    if (rst) begin
      frame_len  = 0;
      lamp_state = '0;
      response_q.delete();
    end else begin
      if (cmd_valid && cmd_ready) response_q.push_back(apply_cmd(cmd));
      if (rsp_valid && rsp_ready) begin
        if (response_q.size() == 0) begin
          report($sformatf("response beat %0h with nothing expected", rsp));
        end else begin
          want = response_q.pop_front();
          check_field("lamps", rsp.lamps, want.lamps);
          check_field("reply", 8'(rsp.reply), 8'(want.reply));
          check_field("changed", 8'(rsp.changed), 8'(want.changed));
          check_field("change_lamp", 8'(rsp.change_lamp), 8'(want.change_lamp));
          check_field("change_on", 8'(rsp.change_on), 8'(want.change_on));
        end
      end
    end
    owed = response_q.size();
  end

endmodule

// ===== sim/serial_lamp_command_parser_tb.sv =====
// Testbench top for the serial lamp command parser: clock, reset, command and response
// traffic with random idling and a long response hold-off, and the final verdict.
// Depends on slcp_pkg, serial_lamp_command_parser and slcp_checker.
module serial_lamp_command_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk;
  logic           rst       = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_ready;
  slcp_pkg::cmd_t cmd       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  slcp_pkg::rsp_t rsp;
  int             errors;
  int             pending;

  // Traffic shaping shared by the two sides
  logic quiet    = 1'b0;
  logic hold_req = 1'b0;
  int   n_items  = 0;

  serial_lamp_command_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  slcp_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one command beat, sometimes idling first, and wait for acceptance
  task automatic send_item(input slcp_pkg::cmd_t c);
    if (!quiet && $urandom_range(99) < 7) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    n_items++;
    quiet <= (n_items >= 300 && n_items < 450);
    if (n_items == 100) hold_req <= 1'b1;
  endtask

  task automatic send_byte(input slcp_pkg::char_t b);
    slcp_pkg::cmd_t c;
    c.action       = slcp_pkg::ACT_BYTE;
    c.rx_byte      = b;
    c.button_index = slcp_pkg::LAMP_IW'($urandom);
    send_item(c);
  endtask

  task automatic send_button(input logic [slcp_pkg::LAMP_IW-1:0] idx);
    slcp_pkg::cmd_t c;
    c.action       = slcp_pkg::ACT_BUTTON;
    c.rx_byte      = slcp_pkg::CHAR_W'($urandom);
    c.button_index = idx;
    send_item(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic slcp_pkg::char_t any_but_end();
    slcp_pkg::char_t b;
    b = slcp_pkg::CHAR_W'($urandom_range(0, 255));
    if (b == slcp_pkg::CH_END) b = ~b;
    return b;
  endfunction

  // One frame, either well formed or damaged in one of several ways, with button presses mixed in between bytes
  task automatic random_frame();
    slcp_pkg::char_t q [$];
    int              kind;
    int              pos;
    kind = $urandom_range(0, 9);
    q = {slcp_pkg::CH_START, slcp_pkg::CH_M,
         slcp_pkg::CHAR_W'(slcp_pkg::CH_ZERO + $urandom_range(0, 7)),
         slcp_pkg::CH_SEMI, slcp_pkg::CH_O};
    if ($urandom_range(1)) q.push_back(slcp_pkg::CH_N);
    else q = {q, slcp_pkg::CH_F, slcp_pkg::CH_F};
    case (kind)
      // lamp digit replaced, usually by one outside the legal range
      5: begin
        case ($urandom_range(0, 2))
          0: q[2] = slcp_pkg::CH_ZERO - 8'd1;
          1: q[2] = slcp_pkg::CH_SEVEN + 8'd1;
          default: q[2] = any_but_end();
        endcase
      end
      // too long: extra bytes after a good prefix, or plain junk past saturation
      7: begin
        if ($urandom_range(1)) begin
          repeat ($urandom_range(1, 4)) q.push_back(any_but_end());
        end else begin
          q.delete();
          repeat ($urandom_range(8, 12)) q.push_back(any_but_end());
        end
      end
      // short frame, down to a lone terminator
      8: begin
        q.delete();
        repeat ($urandom_range(0, 5)) q.push_back(any_but_end());
      end
      // line noise, may contain terminators anywhere
      9: begin
        q.delete();
        repeat ($urandom_range(1, 6)) q.push_back(slcp_pkg::CHAR_W'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    if (kind != 9) q.push_back(slcp_pkg::CH_END);
    // single flipped bit somewhere before the terminator
    if (kind == 6) begin
      pos    = $urandom_range(0, q.size() - 2);
      q[pos] = q[pos] ^ slcp_pkg::CHAR_W'(1 << $urandom_range(0, 7));
    end
    foreach (q[i]) begin
      if ($urandom_range(99) < 15) send_button(slcp_pkg::LAMP_IW'($urandom_range(0, 7)));
      send_byte(q[i]);
    end
  endtask

  // Response side: random stalls, one long hold-off to back the block up
  initial begin
    int   stall_left;
    logic hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = 79;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  // Command side and verdict
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: button toggles, command with no effect, top lamp, short junk frame
    send_button(3'd0);
    send_text(">M0;ON<");
    send_text(">M7;ON<");
    send_button(3'd7);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(slcp_pkg::CH_END);

    while (n_items < 750) random_frame();
    cmd_valid <= 1'b0;

    // Drain, then let the pipeline settle
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("serial_lamp_command_parser: match");
    end else begin
      $display("serial_lamp_command_parser: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("serial_lamp_command_parser: mismatch");
    $finish;
  end

endmodule
